// ----- sv/bounded_stack_with_search_macros.svh -----
// Assertion helpers for the stack block.
// All checks are clocked on aclk; the first form is held off during reset.
`ifndef BOUNDED_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

`define BSWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define BSWS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define BSWS_ASSERT(lbl, prop, msg)

`define BSWS_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ----- sv/bsws_pkg.sv -----
`default_nettype none

package bsws_pkg;

    // default sizes
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;

    // result beat: accepted, found, is_empty, occupancy, free_slots, top, bottom
    localparam int RES_W      = 3 + OCC_W + OCC_W + DATA_W + DATA_W;
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W      = M_TDATA_W - RES_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic in_load;
        logic exec;
        logic acc;
        logic push;
        logic pop;
        logic clear;
        logic scan_step;
        logic pop_rd;
        logic pop_ld;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cnt_zero;
        logic             can_push;
        logic             search_done;
        logic             out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/bounded_stack_with_search.sv -----
`default_nettype none

// Bounded LIFO stack with linear search. Each input beat carries a command on
// s_tuser (push, pop, clear, search) and a value on s_tdata; each one yields
// exactly one result beat describing the stack after the command. Items are
// handled one at a time by a small sequencer over a single-port entry memory.
// After the accept state each command passes the execute state and then waits
// in the done state until the output register is free. A pop that leaves
// entries behind first refetches the new top through the registered memory
// read; a search scans the stack, reading one stored entry per cycle, and a
// hit ends the scan early. A finished result sits in an output register, so
// the next beat is taken while it waits for m_tready.
// capacity (cfg_wdata, reset 16) may only be written while the block is idle.
module bounded_stack_with_search #(
    parameter int DEPTH       = bsws_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bsws_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [bsws_pkg::DATA_W-1:0]        s_tdata,   // value
    input  wire logic [bsws_pkg::CMD_W-1:0]         s_tuser,   // command
    input  wire logic                               cfg_we,
    input  wire logic [bsws_pkg::CAP_W-1:0]         cfg_wdata, // capacity
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // accepted, found, is_empty, occupancy[4:0], free_slots[4:0],
    // top_value[31:0], bottom_value[31:0], zero pad
    output logic [bsws_pkg::M_TDATA_W-1:0]          m_tdata
);

    bsws_pkg::dp_cmd_t dp_cmd;
    bsws_pkg::dp_sts_t dp_sts;

    bsws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    bsws_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- sv/bsws_dp.sv -----
`default_nettype none

`include "bounded_stack_with_search_macros.svh"

module bsws_dp #(
    parameter int DEPTH       = bsws_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bsws_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire bsws_pkg::dp_cmd_t              cmd,
    output bsws_pkg::dp_sts_t                   sts,
    input  wire logic [bsws_pkg::DATA_W-1:0]    s_tdata,
    input  wire logic [bsws_pkg::CMD_W-1:0]     s_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [bsws_pkg::CAP_W-1:0]     cfg_wdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bsws_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = bsws_pkg::CAP_W + CNT_W;
    localparam int DW     = bsws_pkg::DATA_W;
    localparam int OW     = bsws_pkg::OCC_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    // entry storage, read port registered
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rdata_reg;

    logic [bsws_pkg::CMD_W-1:0] cmd_reg;
    logic [VALUE_WIDTH-1:0]     val_reg;
    logic [VALUE_WIDTH-1:0]     top_reg;
    logic [VALUE_WIDTH-1:0]     bottom_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [bsws_pkg::CAP_W-1:0] cap_reg;
    logic                       acc_reg;
    logic                       found_reg;
    logic [CNT_W-1:0]           scan_idx_reg;
    logic                       cmp_vld_reg;
    logic                       m_tvalid_reg;
    logic [bsws_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // value width adaption
    logic [DW+VALUE_WIDTH-1:0]  in_ext;
    logic [VALUE_WIDTH-1:0]     in_val;
    logic [DW+VALUE_WIDTH-1:0]  top_ext;
    logic [DW+VALUE_WIDTH-1:0]  bot_ext;
    logic [DW-1:0]              top_out;
    logic [DW-1:0]              bot_out;

    assign in_ext  = {{VALUE_WIDTH{1'b0}}, s_tdata};
    assign in_val  = in_ext[VALUE_WIDTH-1:0];
    assign top_ext = {{DW{1'b0}}, top_reg};
    assign bot_ext = {{DW{1'b0}}, bottom_reg};

    // capacity limit and free slots
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] free_full;
    logic [CNT_W-1:0] count_m1;
    logic             cnt_zero;
    logic             scan_issue;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CMP_W-1:0] occ_ext;

    assign cap_ext   = {{CNT_W{1'b0}}, cap_reg};
    assign cnt_ext   = {{bsws_pkg::CAP_W{1'b0}}, count_reg};
    assign eff_cap   = (cap_ext < DEPTH_CMP) ? cap_ext : DEPTH_CMP;
    assign free_full = (eff_cap > cnt_ext) ? (eff_cap - cnt_ext) : '0;
    assign count_m1  = count_reg - CNT_W'(1);
    assign cnt_zero  = (count_reg == '0);
    assign occ_ext   = cnt_ext;

    assign top_out = cnt_zero ? '0 : top_ext[DW-1:0];
    assign bot_out = cnt_zero ? '0 : bot_ext[DW-1:0];

    // search scan issues one read a cycle until a hit or the last entry
    assign scan_issue = cmd.scan_step && (scan_idx_reg < count_reg) && !found_reg;
    assign rd_en      = cmd.pop_rd || scan_issue;
    assign rd_addr    = cmd.pop_rd ? count_m1[ADDR_W-1:0] : scan_idx_reg[ADDR_W-1:0];

    // status to controller
    assign sts.cmd         = cmd_reg;
    assign sts.cnt_zero    = cnt_zero;
    assign sts.can_push    = (cnt_ext < eff_cap);
    assign sts.search_done = !cmp_vld_reg && (found_reg || (scan_idx_reg == count_reg));
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    // entry count
    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_m1;
        end else if (cmd.clear) begin
            count_next = '0;
        end
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            cap_reg      <= bsws_pkg::CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[count_reg[ADDR_W-1:0]] <= val_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // item payload, top/bottom cache and search state
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            cmd_reg <= s_tuser;
            val_reg <= in_val;
        end
        if (cmd.exec) begin
            acc_reg      <= cmd.acc;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end else if (cmd.scan_step) begin
            cmp_vld_reg <= scan_issue;
            if (scan_issue) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            if (cmp_vld_reg && (rdata_reg == val_reg)) begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.push) begin
            top_reg <= val_reg;
            if (cnt_zero) begin
                bottom_reg <= val_reg;
            end
        end
        if (cmd.pop_ld) begin
            top_reg <= rdata_reg;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {{bsws_pkg::PAD_W{1'b0}}, bot_out, top_out,
                            free_full[OW-1:0], occ_ext[OW-1:0],
                            cnt_zero, found_reg, acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BSWS_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "entry count above depth")
    `BSWS_ASSERT(a_push_room, cmd.push |-> (cnt_ext < eff_cap), "push issued with stack full")
    `BSWS_ASSERT(a_out_slot, cmd.out_load |-> (!m_tvalid_reg || m_tready), "result overwritten")
    `BSWS_ASSERT(a_pop_nonzero, cmd.pop |-> !cnt_zero, "pop issued on empty stack")
    `BSWS_ASSERT_RST(a_rst_idle, !aresetn |=> !m_tvalid_reg, "result valid after reset")

endmodule

`default_nettype wire

// ----- sv/bsws_ctrl.sv -----
`default_nettype none

module bsws_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire bsws_pkg::dp_sts_t  sts,
    output bsws_pkg::dp_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_POP_RD = 3'd2;
    localparam logic [2:0] S_POP_LD = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
                case (sts.cmd)
                    bsws_pkg::CMD_PUSH: begin
                        if (sts.can_push) begin
                            cmd.push = 1'b1;
                            cmd.acc  = 1'b1;
                        end
                    end
                    bsws_pkg::CMD_POP: begin
                        if (!sts.cnt_zero) begin
                            cmd.pop    = 1'b1;
                            cmd.acc    = 1'b1;
                            state_next = S_POP_RD;
                        end
                    end
                    bsws_pkg::CMD_CLEAR: begin
                        cmd.clear = 1'b1;
                        cmd.acc   = 1'b1;
                    end
                    bsws_pkg::CMD_SEARCH: begin
                        cmd.acc    = 1'b1;
                        state_next = S_SEARCH;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP_RD: begin
                // refetch the new top unless the pop emptied the stack
                if (sts.cnt_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP_LD;
                end
            end
            S_POP_LD: begin
                cmd.pop_ld = 1'b1;
                state_next = S_DONE;
            end
            S_SEARCH: begin
                cmd.scan_step = 1'b1;
                if (sts.search_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/bounded_stack_with_search_test.sv -----
`default_nettype none

module bounded_stack_with_search_test;

    localparam int STACK_DEPTH = bsws_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;

    // one stack command as offered on the input stream
    typedef struct packed {
        logic [bsws_pkg::CMD_W-1:0]  cmd;
        logic [bsws_pkg::DATA_W-1:0] value;
    } stack_op_t;

    // result beat, lowest field last so it maps straight onto m_tdata
    typedef struct packed {
        logic [bsws_pkg::DATA_W-1:0] bottom;
        logic [bsws_pkg::DATA_W-1:0] top;
        logic [bsws_pkg::OCC_W-1:0]  free_slots;
        logic [bsws_pkg::OCC_W-1:0]  occupancy;
        logic                        is_empty;
        logic                        found;
        logic                        accepted;
    } stack_res_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [bsws_pkg::DATA_W-1:0]    s_tdata   = '0;
    logic [bsws_pkg::CMD_W-1:0]     s_tuser   = bsws_pkg::CMD_PUSH;
    logic                           cfg_we    = 1'b0;
    logic [bsws_pkg::CAP_W-1:0]     cfg_wdata = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [bsws_pkg::M_TDATA_W-1:0] m_tdata;

    // stimulus and scoreboard state
    stack_op_t  pend_q[$];
    stack_res_t exp_q[$];
    int         queued_cnt = 0;
    int         taken_cnt  = 0;
    int         err_cnt    = 0;
    int         cycle_cnt  = 0;
    bit         s_fire     = 0;
    bit         m_fire     = 0;
    bit         tx_no_gap  = 0;
    bit         rx_no_stall = 0;
    bit         long_hold_req = 0;
    logic [bsws_pkg::DATA_W-1:0] val_pool[8];

    // shadow of the stack
    logic [bsws_pkg::DATA_W-1:0] shadow_mem[STACK_DEPTH];
    int                          shadow_cnt = 0;
    logic [bsws_pkg::CAP_W-1:0]  shadow_cap = bsws_pkg::CAP_RESET;

    bounded_stack_with_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // apply one command to the shadow stack and return the resulting beat
    function automatic stack_res_t apply_stack_cmd(logic [bsws_pkg::CMD_W-1:0] cmd,
                                                   logic [bsws_pkg::DATA_W-1:0] value);
        stack_res_t r;
        int         lim;
        r   = '0;
        lim = (shadow_cap < STACK_DEPTH) ? int'(shadow_cap) : STACK_DEPTH;
        case (cmd)
            bsws_pkg::CMD_PUSH: begin
                if (shadow_cnt < lim) begin
                    shadow_mem[shadow_cnt] = value;
                    shadow_cnt++;
                    r.accepted = 1'b1;
                end
            end
            bsws_pkg::CMD_POP: begin
                if (shadow_cnt > 0) begin
                    shadow_cnt--;
                    r.accepted = 1'b1;
                end
            end
            bsws_pkg::CMD_CLEAR: begin
                shadow_cnt = 0;
                r.accepted = 1'b1;
            end
            default: begin
                for (int i = 0; i < shadow_cnt; i++)
                    if (shadow_mem[i] == value) r.found = 1'b1;
                r.accepted = 1'b1;
            end
        endcase
        r.is_empty   = (shadow_cnt == 0);
        r.occupancy  = shadow_cnt[bsws_pkg::OCC_W-1:0];
        r.free_slots = (lim > shadow_cnt) ? bsws_pkg::OCC_W'(lim - shadow_cnt) : '0;
        if (shadow_cnt > 0) begin
            r.top    = shadow_mem[shadow_cnt-1];
            r.bottom = shadow_mem[0];
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [bsws_pkg::DATA_W-1:0] want,
                               logic [bsws_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // driver: at a falling edge, sends the next command after any random gap
    always @(negedge aclk) begin
        stack_op_t cur;
        int        tx_gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_tvalid || s_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                cur = pend_q.pop_front();
                s_tuser  <= cur.cmd;
                s_tdata  <= cur.value;
                s_tvalid <= 1'b1;
                tx_gap = tx_no_gap ? 0 : $urandom_range(0, 10);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready: a random wait per beat, plus the occasional long hold
    always @(negedge aclk) begin
        int rx_wait;
        int hold_cnt;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
            hold_cnt = 0;
        end else begin
            if (long_hold_req) begin
                hold_cnt      = LONG_HOLD;
                long_hold_req = 0;
            end
            if (m_fire) rx_wait = rx_no_stall ? 0 : $urandom_range(0, 10);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on each input beat, check each result beat
    always @(posedge aclk) begin
        stack_res_t got;
        stack_res_t want;
        cycle_cnt++;
        s_fire = s_tvalid && s_tready;
        m_fire = m_tvalid && m_tready;
        if (!aresetn) begin
            shadow_cnt = 0;
            shadow_cap = bsws_pkg::CAP_RESET;
        end else if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            if (cfg_we) shadow_cap = cfg_wdata;
            if (m_fire) begin
                got = m_tdata[bsws_pkg::RES_W-1:0];
                if (exp_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got);
                end else begin
                    want = exp_q.pop_front();
                    check_field("accepted",   want.accepted,   got.accepted);
                    check_field("found",      want.found,      got.found);
                    check_field("is_empty",   want.is_empty,   got.is_empty);
                    check_field("occupancy",  want.occupancy,  got.occupancy);
                    check_field("free_slots", want.free_slots, got.free_slots);
                    check_field("top_value",  want.top,        got.top);
                    check_field("bottom_value", want.bottom,   got.bottom);
                end
            end
            if (s_fire) begin
                exp_q.push_back(apply_stack_cmd(s_tuser, s_tdata));
                taken_cnt++;
            end
        end
    end

    task automatic queue_cmd(logic [bsws_pkg::CMD_W-1:0] cmd,
                             logic [bsws_pkg::DATA_W-1:0] value);
        stack_op_t op;
        op.cmd   = cmd;
        op.value = value;
        pend_q.push_back(op);
        queued_cnt++;
    endtask

    // hold the sender until every beat is taken and every result is back
    task automatic wait_drained();
        while (taken_cnt != queued_cnt || exp_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_capacity(logic [bsws_pkg::CAP_W-1:0] cap);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // random mix weighted toward pushes so the stack runs deep; values often
    // repeat from a small pool so searches hit
    task automatic queue_random_mix(int count);
        int                          pick;
        logic [bsws_pkg::CMD_W-1:0]  cmd;
        logic [bsws_pkg::DATA_W-1:0] value;
        val_pool[0] = '0;
        val_pool[1] = '1;
        for (int i = 2; i < 8; i++) val_pool[i] = $urandom();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      cmd = bsws_pkg::CMD_PUSH;
            else if (pick < 70) cmd = bsws_pkg::CMD_POP;
            else if (pick < 97) cmd = bsws_pkg::CMD_SEARCH;
            else                cmd = bsws_pkg::CMD_CLEAR;
            value = $urandom_range(0, 1) ? val_pool[3'($urandom_range(0, 7))] : $urandom();
            queue_cmd(cmd, value);
        end
        // top the stack up with a random number of pushes for the next capacity
        pick = $urandom_range(0, STACK_DEPTH);
        for (int i = 0; i < pick; i++) queue_cmd(bsws_pkg::CMD_PUSH, $urandom());
    endtask

    initial begin
        logic [bsws_pkg::CAP_W-1:0] cap_seq[10];
        cap_seq = '{5'd31, 5'd0, 5'd16, 5'd5, 5'd1, 5'd17, 5'd8, 5'd3, 5'd0, 5'd16};
        cap_seq[8] = bsws_pkg::CAP_W'($urandom_range(0, 31));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty stack corners, extreme values, stale entries after clear
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_CLEAR,  32'hFFFF_FFFF);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'hFFFF_FFFF);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'h5A5A_A5A5);
        queue_cmd(bsws_pkg::CMD_POP,    32'hFFFF_FFFF);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h8000_0000);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h0000_0001);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_CLEAR,  32'h0000_0000);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'h8000_0000);

        // tiny capacity: push into a full stack
        write_capacity(5'd2);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'h1234_5678);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'hCAFE_0001);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'hDEAD_BEEF);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'hDEAD_BEEF);
        queue_cmd(bsws_pkg::CMD_POP,    32'h0000_0000);

        // capacity dropped below occupancy
        write_capacity(5'd0);
        queue_cmd(bsws_pkg::CMD_PUSH,   32'hAAAA_5555);
        queue_cmd(bsws_pkg::CMD_SEARCH, 32'h1234_5678);

        // random phases, one capacity each
        for (int ph = 0; ph < 10; ph++) begin
            write_capacity(cap_seq[ph]);
            tx_no_gap   = (ph == 2 || ph == 5 || ph == 7);
            rx_no_stall = (ph == 5);
            if (ph == 2 || ph == 7) long_hold_req = 1;
            queue_random_mix(120);
        end

        wait_drained();
        repeat (30) @(negedge aclk);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
